[rtl/per_flow_token_bucket_shaper_defines.svh]
// Assertion macros for the per-flow token-bucket shaper.
`ifndef PER_FLOW_TOKEN_BUCKET_SHAPER_DEFINES_SVH
`define PER_FLOW_TOKEN_BUCKET_SHAPER_DEFINES_SVH
// Implication checked on every clock, disabled in reset.
`define PFTB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled in reset.
`define PFTB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/pftb_pkg.sv]
// Shared types and constants for the per-flow token-bucket shaper.
`timescale 1ns / 1ps
`default_nettype none
package pftb_pkg;
   localparam int NUM_FLOWS          = 64;
   localparam int QUEUE_DEPTH        = 256;
   localparam int MAX_SENDS_PER_TICK = 63;
   localparam int FLOW_W  = 6;
   localparam int SLOT_W  = 8;
   localparam int COUNT_W = 9;
   localparam int TOK_W   = 18;
   localparam int SENT_W  = 6;
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_W     = 2;

   localparam logic [TOK_W-1:0] TOKENS_AT_RESET = 18'd32768;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_DROP   = 2'd1;
   localparam logic [1:0] KIND_SENT   = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   localparam logic [1:0] CSR_RATE  = 2'd0;
   localparam logic [1:0] CSR_BURST = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   typedef struct packed {
      logic        is_tick;
      logic [FLOW_W-1:0] flow;
      logic [15:0] len;
      logic [15:0] handle;
      logic [9:0]  elapsed;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [FLOW_W-1:0] flow;
      logic [15:0] handle;
      logic [15:0] len;
      logic        last;
   } rsp_type;

   // per-flow bucket and queue pointers, one memory word per flow
   typedef struct packed {
      logic [TOK_W-1:0]   tok;
      logic [SLOT_W-1:0]  head;
      logic [COUNT_W-1:0] cnt;
   } flow_type;
endpackage
`default_nettype wire

[rtl/pftb_front.sv]
// Input stage and command queue: takes words in and buffers them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module pftb_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire pftb_pkg::cmd_type     cmd_in,
   output logic                       cmd_valid,
   input  wire logic                  cmd_take,
   output pftb_pkg::cmd_type          cmd_out
);
   pftb_pkg::cmd_type                 q_mem [pftb_pkg::CMDQ_DEPTH];
   logic [pftb_pkg::CMDQ_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [pftb_pkg::CMDQ_W:0]         cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   assign full      = (cnt_ff == 3'(pftb_pkg::CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_out   = q_mem[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, do_push} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wr_ff] <= cmd_in;
      end
   end
endmodule
`default_nettype wire

[rtl/pftb_back.sv]
// Engine: reset-time clear, enqueue, refill sweep and dispatch scan over the flow queues.
`timescale 1ns / 1ps
`default_nettype none
`include "per_flow_token_bucket_shaper_defines.svh"
module pftb_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output logic                       cmd_take,
   input  wire pftb_pkg::cmd_type     cmd,
   input  wire logic [11:0]           rate,
   input  wire logic [15:0]           burst,
   input  wire logic [8:0]            limit,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pftb_pkg::rsp_type          rsp
);
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ENQ    = 3'd2;
   localparam logic [2:0] ST_REFILL = 3'd3;
   localparam logic [2:0] ST_LOOK   = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   localparam int FW = pftb_pkg::FLOW_W;
   localparam int SW = pftb_pkg::SENT_W;
   localparam int CW = pftb_pkg::COUNT_W;
   localparam logic [FW-1:0] LAST_FLOW = FW'(pftb_pkg::NUM_FLOWS - 1);
   localparam logic [SW-1:0] SENT_CAP  = SW'(pftb_pkg::MAX_SENDS_PER_TICK);

   logic [2:0]                        st_ff, st_in;
   logic [FW-1:0]                     f_ff, f_in;
   logic [SW-1:0]                     sent_ff, sent_in;
   logic [21:0]                       add_ff;
   logic [17:0]                       cap_ff;
   logic                              ovalid_ff;
   pftb_pkg::rsp_type                 orsp_ff;

   // per-flow state memory, read through flow_rd_ff, which the scan also updates
   pftb_pkg::flow_type                flow_mem [pftb_pkg::NUM_FLOWS];
   pftb_pkg::flow_type                flow_rd_ff;
   logic [31:0]                       store_mem [pftb_pkg::NUM_FLOWS * pftb_pkg::QUEUE_DEPTH];
   logic [31:0]                       rd_data_ff;

   logic                              out_free;
   logic                              enq_ok;
   logic [pftb_pkg::SLOT_W-1:0]       slot;
   logic [22:0]                       tsum;
   logic [17:0]                       cost;
   logic                              can_send;
   logic                              st_wr, st_rd;
   logic                              fl_rd, fl_wr, fl_upd;
   logic [FW-1:0]                     fl_raddr, fl_waddr;
   pftb_pkg::flow_type                fl_wdata;
   logic                              res_en;
   pftb_pkg::rsp_type                 res;

   assign out_free = !ovalid_ff || rsp_ready;
   assign enq_ok   = (flow_rd_ff.cnt < limit) &&
                     (flow_rd_ff.cnt < CW'(pftb_pkg::QUEUE_DEPTH));
   assign slot     = flow_rd_ff.head + flow_rd_ff.cnt[pftb_pkg::SLOT_W-1:0];
   assign tsum     = {5'b0, flow_rd_ff.tok} + {1'b0, add_ff};
   assign cost     = {rd_data_ff[31:16], 2'b00};
   assign can_send = (flow_rd_ff.tok >= cost);
   assign rsp_valid = ovalid_ff;
   assign rsp       = orsp_ff;

   always_comb begin
      st_in    = st_ff;
      f_in     = f_ff;
      sent_in  = sent_ff;
      cmd_take = 1'b0;
      st_wr    = 1'b0;
      st_rd    = 1'b0;
      fl_rd    = 1'b0;
      fl_raddr = f_ff + 1'b1;
      fl_wr    = 1'b0;
      fl_waddr = f_ff;
      fl_wdata = flow_rd_ff;
      fl_upd   = 1'b0;
      res_en   = 1'b0;
      res      = '{kind: pftb_pkg::KIND_SENT, flow: f_ff, handle: rd_data_ff[15:0],
                   len: rd_data_ff[31:16], last: 1'b0};
      case (st_ff)
         ST_CLEAR: begin
            fl_wr    = 1'b1;
            fl_wdata = '{tok: pftb_pkg::TOKENS_AT_RESET, head: '0, cnt: '0};
            f_in     = f_ff + 1'b1;
            if (f_ff == LAST_FLOW) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               fl_rd = 1'b1;
               if (cmd.is_tick) begin
                  fl_raddr = '0;
                  cmd_take = 1'b1;
                  st_in    = ST_REFILL;
                  f_in     = '0;
                  sent_in  = '0;
               end else begin
                  fl_raddr = cmd.flow;
                  st_in    = ST_ENQ;
               end
            end
         end
         ST_ENQ: begin
            if (out_free) begin
               cmd_take     = 1'b1;
               res_en       = 1'b1;
               res          = '{kind: enq_ok ? pftb_pkg::KIND_ACCEPT : pftb_pkg::KIND_DROP,
                                flow: cmd.flow, handle: cmd.handle, len: cmd.len,
                                last: 1'b1};
               st_wr        = enq_ok;
               fl_wr        = enq_ok;
               fl_waddr     = cmd.flow;
               fl_wdata.cnt = flow_rd_ff.cnt + 1'b1;
               st_in        = ST_IDLE;
            end
         end
         ST_REFILL: begin
            // write back flow f while the read of flow f+1 is under way
            fl_wr        = 1'b1;
            fl_wdata.tok = (tsum > {5'b0, cap_ff}) ? cap_ff : tsum[17:0];
            fl_rd        = 1'b1;
            f_in         = f_ff + 1'b1;
            if (f_ff == LAST_FLOW) begin
               st_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (sent_ff == SENT_CAP) begin
               st_in = ST_DONE;
            end else if (flow_rd_ff.cnt != '0) begin
               st_rd = 1'b1;
               st_in = ST_DECIDE;
            end else if (f_ff == LAST_FLOW) begin
               st_in = ST_DONE;
            end else begin
               fl_rd = 1'b1;
               f_in  = f_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            if (!can_send) begin
               if (f_ff == LAST_FLOW) begin
                  st_in = ST_DONE;
               end else begin
                  fl_rd = 1'b1;
                  f_in  = f_ff + 1'b1;
                  st_in = ST_LOOK;
               end
            end else if (out_free) begin
               fl_wr         = 1'b1;
               fl_upd        = 1'b1;
               fl_wdata.tok  = flow_rd_ff.tok - cost;
               fl_wdata.head = flow_rd_ff.head + 1'b1;
               fl_wdata.cnt  = flow_rd_ff.cnt - 1'b1;
               res_en        = 1'b1;
               sent_in       = sent_ff + 1'b1;
               st_in         = ST_LOOK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               res_en = 1'b1;
               res    = '{kind: pftb_pkg::KIND_DONE, flow: '0, handle: '0, len: '0,
                          last: 1'b1};
               st_in  = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_CLEAR;
         f_ff      <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         f_ff  <= f_in;
         if (res_en) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sent_ff <= sent_in;
      if (cmd_take && cmd.is_tick) begin
         add_ff <= 22'(cmd.elapsed) * 22'(rate);
         cap_ff <= {burst, 2'b00};
      end
      if (res_en) begin
         orsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (fl_wr) begin
         flow_mem[fl_waddr] <= fl_wdata;
      end
      if (fl_rd) begin
         flow_rd_ff <= flow_mem[fl_raddr];
      end else if (fl_upd) begin
         flow_rd_ff <= fl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (st_wr) begin
         store_mem[{cmd.flow, slot}] <= {cmd.len, cmd.handle};
      end
      if (st_rd) begin
         rd_data_ff <= store_mem[{f_ff, flow_rd_ff.head}];
      end
   end

   `PFTB_ASSERT_IMP(a_take_state, cmd_take, (st_ff == ST_IDLE || st_ff == ST_ENQ),
      "command taken while busy")
   `PFTB_ASSERT_IMP(a_sent_cap, st_ff == ST_DECIDE, sent_ff != SENT_CAP, "send cap exceeded")
   `PFTB_ASSERT_IMP(a_res_room, res_en, out_free, "result register overwritten")
   `PFTB_ASSERT_NXT(a_send_out, fl_upd, rsp_valid && rsp.kind == pftb_pkg::KIND_SENT,
      "send not presented")
endmodule
`default_nettype wire

[rtl/per_flow_token_bucket_shaper.sv]
// Top level of the per-flow token-bucket shaper.
`timescale 1ns / 1ps
`default_nettype none
// Per-flow token-bucket shaper. Words enter through a four-deep command queue
// (push/full) and leave through a one-word result register (empty/pop).
// After reset the engine writes the per-flow state of all 64 flows (full
// buckets, empty queues); words pushed meanwhile wait in the command queue.
// An enqueue reads the flow state, then updates it and answers, and yields
// one accepted or dropped word. A tick is taken from the queue, refills all
// 64 buckets in one pipelined sweep, then scans the flows in order, reading
// the head packet of each nonempty flow from the packet store, and ends with
// a done word. The flow state and the packet store are memories with one
// read and one write port, each read through a register; a full result
// register stalls the engine when it has a word to give. Tokens are quarter
// bytes; at most 63 sends per tick. Configuration writes are always taken
// (csr_ready high) and belong where no command is in flight.
module per_flow_token_bucket_shaper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_cmd,
   input  wire logic [5:0]  req_flow,
   input  wire logic [15:0] req_pkt_len,
   input  wire logic [15:0] req_pkt_handle,
   input  wire logic [9:0]  req_elapsed_ms,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_kind,
   output logic [5:0]       rsp_out_flow,
   output logic [15:0]      rsp_out_handle,
   output logic [15:0]      rsp_out_len,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   logic [11:0]        rate_ff;
   logic [15:0]        burst_ff;
   logic [8:0]         limit_ff;
   pftb_pkg::cmd_type  cmd_in, cmd_q;
   pftb_pkg::rsp_type  rsp_w;
   logic               cmd_valid, cmd_take, rsp_valid;

   assign csr_ready = 1'b1;
   assign cmd_in = '{is_tick: req_cmd, flow: req_flow, len: req_pkt_len,
                     handle: req_pkt_handle, elapsed: req_elapsed_ms};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= 12'd15;
         burst_ff <= 16'd8192;
         limit_ff <= 9'd201;
      end else if (csr_valid) begin
         case (csr_index)
            pftb_pkg::CSR_RATE:  rate_ff  <= csr_data[11:0];
            pftb_pkg::CSR_BURST: burst_ff <= csr_data;
            pftb_pkg::CSR_LIMIT: limit_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   pftb_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .cmd_in(cmd_in),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_out(cmd_q)
   );

   pftb_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd(cmd_q), .rate(rate_ff), .burst(burst_ff), .limit(limit_ff),
      .rsp_valid(rsp_valid), .rsp_ready(pop), .rsp(rsp_w)
   );

   assign empty          = !rsp_valid;
   assign rsp_kind       = rsp_w.kind;
   assign rsp_out_flow   = rsp_w.flow;
   assign rsp_out_handle = rsp_w.handle;
   assign rsp_out_len    = rsp_w.len;
   assign rsp_last       = rsp_w.last;
endmodule
`default_nettype wire
